// ----- rtl/sks_pkg.sv -----
package sks_pkg;

  // field widths of the request and result transfers
  localparam int KEY_W = 16;
  localparam int OP_W  = 2;
  localparam int CNT_W = 7;

  // request kinds
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;  // latch compare flags against the request key
    logic ins;  // shift up from the insert point and drop the key in
    logic del;  // shift down over the matching entry
  } cell_ctrl_t;

endpackage

// ----- rtl/sks_req_if.sv -----
interface sks_req_if;
  import sks_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);

endinterface

// ----- rtl/sks_rsp_if.sv -----
interface sks_rsp_if;
  import sks_pkg::*;

  logic             valid;
  logic             ready;
  logic             success;
  logic             store_full;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output success, output store_full, output entry_count,
                  input ready);
  modport sink (input valid, input success, input store_full, input entry_count,
                output ready);

endinterface

// ----- rtl/sks_cell.sv -----
module sks_cell #(
  parameter int KEY_BITS = 16,
  parameter int CW       = 7,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  sks_pkg::cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0] key,
  input  logic [CW-1:0]       count,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                left_lt,
  input  logic [KEY_BITS-1:0] right_key,
  output logic [KEY_BITS-1:0] cell_key,
  output logic                lt,
  output logic                eq
);
  import sks_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic occupied;

  assign occupied = IDX_C < count;

  // compare flags, held until the commit
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= occupied && (cell_key < key);
      eq <= occupied && (cell_key == key);
    end
  end

  // entries at or above the insert or delete point move by one slot
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      cell_key <= left_lt ? key : left_key;
    end else if (ctrl.del && !lt) begin
      cell_key <= right_key;
    end
  end

endmodule

// ----- rtl/sorted_key_set.sv -----
// sorted key set: a row of cells holds the keys in ascending order
// each request passes a registered compare phase, then a commit that shifts
// the cell row; a new request is taken only after the commit, which waits
// while a result is untaken, and the result register lets a new request in
// while the previous result waits. reset clears the key count, phase and
// result valid; cell contents are not cleared and no clearing pass is made
module sorted_key_set #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  sks_req_if.sink       req,
  sks_rsp_if.source     rsp
);
  import sks_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_CMP    = 2'd1;
  localparam logic [1:0] PH_COMMIT = 2'd2;

  logic [1:0]            phase;
  logic [OP_W-1:0]       op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [KEY_BITS+KEY_W-1:0] key_ext;
  logic [CW+CNT_W-1:0]   count_ext;
  cell_ctrl_t            ctrl;
  logic                  commit;
  logic                  present;
  logic                  full;
  logic                  ins_go;
  logic                  del_go;
  logic                  ok;
  logic                  refused;
  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;

  // request key cut or padded to the stored width
  assign key_ext = {{KEY_BITS{1'b0}}, req.key};

  assign req.ready = phase == PH_IDLE;

  // sequencer: accept, compare in every cell, commit once the result slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (req.valid) phase <= PH_CMP;
        end
        PH_CMP: phase <= PH_COMMIT;
        PH_COMMIT: begin
          if (commit) phase <= PH_IDLE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r  <= req.op;
      key_r <= key_ext[KEY_BITS-1:0];
    end
  end

  assign commit  = (phase == PH_COMMIT) && (!rsp.valid || rsp.ready);
  assign present = |eq_vec;
  assign full    = count >= CAP_C;

  // decision for the request at commit
  always_comb begin
    ins_go  = 1'b0;
    del_go  = 1'b0;
    ok      = 1'b0;
    refused = 1'b0;
    case (op_r)
      OP_QUERY: ok = present;
      OP_INSERT: begin
        ins_go  = !present && !full;
        ok      = ins_go;
        refused = !present && full;
      end
      OP_DELETE: begin
        del_go = present;
        ok     = present;
      end
      default: ok = 1'b0;
    endcase
  end

  assign ctrl.cmp = phase == PH_CMP;
  assign ctrl.ins = commit && ins_go;
  assign ctrl.del = commit && del_go;

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.del) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign count_ext = {{CNT_W{1'b0}}, count_next};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.success     <= ok;
      rsp.store_full  <= refused;
      rsp.entry_count <= count_ext[CNT_W-1:0];
    end
  end

  // row of cells, each linked to its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0] lk;
    logic                llt;
    logic [KEY_BITS-1:0] rk;

    if (i == 0) begin : g_first
      assign lk  = key_r;
      assign llt = 1'b1;
    end else begin : g_inner
      assign lk  = cell_key[i-1];
      assign llt = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = '0;
    end else begin : g_body
      assign rk = cell_key[i+1];
    end

    sks_cell #(
      .KEY_BITS (KEY_BITS),
      .CW       (CW),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key_r),
      .count     (count),
      .left_key  (lk),
      .left_lt   (llt),
      .right_key (rk),
      .cell_key  (cell_key[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("key count above capacity");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COMMIT) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the count");

  a_full_no_success: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.success && rsp.store_full))
    else $error("refused insert reported success");

  a_commit_phase: assert property (@(posedge clk) disable iff (rst)
    commit |=> phase == PH_IDLE && rsp.valid)
    else $error("commit did not post a result");

endmodule
